// File: hw/rtl/ptned_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptned_pkg
// Shared types and fixed widths of the nearest edge distance unit.
// ----------------------------------------------------------------------------
package ptned_pkg;

    localparam int COORD_BITS  = 20;
    localparam int CORNER_BITS = 3 * COORD_BITS;
    localparam int DIFF_BITS   = COORD_BITS + 1;      // p - a, b - a
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int DOT_BITS    = PROD_BITS + 2;       // sum of three products
    localparam int FOOT_BITS   = DIFF_BITS + 2;       // signed offset from foot
    localparam int SQ_BITS     = 2 * (FOOT_BITS - 1); // one squared term
    localparam int SUMSQ_BITS  = SQ_BITS + 2;
    localparam int ROOT_STEPS  = SUMSQ_BITS / 2;
    localparam int DIST_BITS   = 21;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic [CORNER_BITS-1:0]       corner_a;
        logic [CORNER_BITS-1:0]       corner_b;
        logic [CORNER_BITS-1:0]       corner_c;
        logic [CORNER_BITS-1:0]       corner_d;
    } t_in_word;

    typedef struct packed {
        logic [DIST_BITS-1:0] edge_distance;
        logic                 nearest_side;
        logic                 degenerate_edge;
    } t_out_word;

    // segment geometry carried along the lane pipeline
    typedef struct packed {
        logic [2:0][DIFF_BITS-1:0] v;   // b - a
        logic [2:0][DIFF_BITS-1:0] w;   // p - a
        logic [2:0][DIFF_BITS-1:0] u;   // p - b
        logic                      lo;  // projection before first endpoint
        logic                      hi;  // projection past second endpoint
        logic                      dg;  // coincident endpoints
    } t_geo;

    typedef struct packed {
        logic [SUMSQ_BITS-1:0] sq;
        logic                  dg;
    } t_lane_res;

endpackage

// File: hw/rtl/ptned_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptned_lane
// Squared distance from a point to one segment, fully pipelined.
// ----------------------------------------------------------------------------
module ptned_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic signed [ptned_pkg::COORD_BITS-1:0] i_px,
    input  logic signed [ptned_pkg::COORD_BITS-1:0] i_py,
    input  logic signed [ptned_pkg::COORD_BITS-1:0] i_pz,
    input  logic [ptned_pkg::CORNER_BITS-1:0]       i_a,
    input  logic [ptned_pkg::CORNER_BITS-1:0]       i_b,
    output ptned_pkg::t_lane_res                    o_res
);
    localparam int CB   = ptned_pkg::COORD_BITS;
    localparam int DW   = ptned_pkg::DIFF_BITS;
    localparam int PW   = ptned_pkg::PROD_BITS;
    localparam int CW   = ptned_pkg::DOT_BITS;
    localparam int FW   = ptned_pkg::FOOT_BITS;
    localparam int QW   = ptned_pkg::SQ_BITS;
    localparam int SW   = ptned_pkg::SUMSQ_BITS;
    localparam int MW   = DW + FRACTION_BITS;
    localparam logic [MW:0] HALF = (MW+1)'(1) << (FRACTION_BITS - 1);

    logic signed [CB-1:0] p [3];
    logic signed [CB-1:0] ea [3];
    logic signed [CB-1:0] eb [3];

    always_comb begin
        p[0]  = i_px;
        p[1]  = i_py;
        p[2]  = i_pz;
        ea[0] = $signed(i_a[3*CB-1:2*CB]);
        ea[1] = $signed(i_a[2*CB-1:CB]);
        ea[2] = $signed(i_a[CB-1:0]);
        eb[0] = $signed(i_b[3*CB-1:2*CB]);
        eb[1] = $signed(i_b[2*CB-1:CB]);
        eb[2] = $signed(i_b[CB-1:0]);
    end

    // differences
    ptned_pkg::t_geo r_g1;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_g1.v[i] <= DW'(eb[i]) - DW'(ea[i]);
            r_g1.w[i] <= DW'(p[i]) - DW'(ea[i]);
            r_g1.u[i] <= DW'(p[i]) - DW'(eb[i]);
        end
        r_g1.lo <= 1'b0;
        r_g1.hi <= 1'b0;
        r_g1.dg <= 1'b0;
    end

    // products
    ptned_pkg::t_geo      r_g2;
    logic signed [PW-1:0] r_wv [3];
    logic signed [PW-1:0] r_vv [3];
    always_ff @(posedge i_clk) begin
        r_g2 <= r_g1;
        for (int i = 0; i < 3; i++) begin
            r_wv[i] <= $signed(r_g1.w[i]) * $signed(r_g1.v[i]);
            r_vv[i] <= $signed(r_g1.v[i]) * $signed(r_g1.v[i]);
        end
    end

    // dot products and range checks
    logic signed [CW-1:0] n_c1;
    logic signed [CW-1:0] n_c2;
    ptned_pkg::t_geo      n_gd;
    always_comb begin
        n_c1    = CW'(r_wv[0]) + CW'(r_wv[1]) + CW'(r_wv[2]);
        n_c2    = CW'(r_vv[0]) + CW'(r_vv[1]) + CW'(r_vv[2]);
        n_gd    = r_g2;
        n_gd.lo = (n_c1 <= 0);
        n_gd.hi = (n_c2 <= n_c1);
        n_gd.dg = (n_c2 == 0);
    end

    ptned_pkg::t_geo r_gd [FRACTION_BITS+1];
    logic [CW-1:0]   r_rem [FRACTION_BITS+1];
    logic [CW-1:0]   r_den [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] r_t [FRACTION_BITS+1];

    always_ff @(posedge i_clk) begin
        r_gd[0]    <= n_gd;
        r_rem[0]   <= n_c1;
        r_den[0]   <= n_c2;
        r_t[0]     <= '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
        logic [CW:0] sh;
        logic        ge;
        always_comb begin
            sh = {r_rem[k], 1'b0};
            ge = (sh >= {1'b0, r_den[k]});
        end
        always_ff @(posedge i_clk) begin
            r_gd[k+1]  <= r_gd[k];
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= ge ? CW'(sh - {1'b0, r_den[k]}) : CW'(sh);
            r_t[k+1]   <= {r_t[k][FRACTION_BITS-2:0], ge};
        end
    end

    // foot offset magnitude
    ptned_pkg::t_geo r_gm;
    logic [MW-1:0]   r_m [3];
    logic [DW-1:0]   n_av [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_av[i] = r_gd[FRACTION_BITS].v[i][DW-1] ? DW'(-r_gd[FRACTION_BITS].v[i])
                                                      : r_gd[FRACTION_BITS].v[i];
        end
    end
    always_ff @(posedge i_clk) begin
        r_gm <= r_gd[FRACTION_BITS];
        for (int i = 0; i < 3; i++) begin
            r_m[i] <= MW'(n_av[i]) * MW'(r_t[FRACTION_BITS]);
        end
    end

    // offset from foot point or from an endpoint
    logic                 r_dg_d;
    logic signed [FW-1:0] r_d [3];
    logic [MW:0]          n_rnd [3];
    logic signed [FW-1:0] n_off [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = ({1'b0, r_m[i]} + HALF) >> FRACTION_BITS;
            n_off[i] = r_gm.v[i][DW-1] ? -$signed(FW'(n_rnd[i])) : $signed(FW'(n_rnd[i]));
        end
    end
    always_ff @(posedge i_clk) begin
        r_dg_d <= r_gm.dg;
        for (int i = 0; i < 3; i++) begin
            priority if (r_gm.lo) begin
                r_d[i] <= FW'($signed(r_gm.w[i]));
            end else if (r_gm.hi) begin
                r_d[i] <= FW'($signed(r_gm.u[i]));
            end else begin
                r_d[i] <= FW'($signed(r_gm.w[i])) - n_off[i];
            end
        end
    end

    // squares
    logic          r_dg_q;
    logic [QW-1:0] r_sq [3];
    logic [FW-2:0] n_ad [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ad[i] = r_d[i][FW-1] ? (FW-1)'(-r_d[i]) : (FW-1)'(r_d[i]);
        end
    end
    always_ff @(posedge i_clk) begin
        r_dg_q <= r_dg_d;
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= n_ad[i] * n_ad[i];
        end
    end

    ptned_pkg::t_lane_res r_res;
    always_ff @(posedge i_clk) begin
        r_res.sq <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        r_res.dg <= r_dg_q;
    end

    assign o_res = r_res;

endmodule

// File: hw/rtl/ptned_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptned_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ptned_isqrt (
    input  logic                               i_clk,
    input  logic [ptned_pkg::SUMSQ_BITS-1:0]   i_val,
    output logic [ptned_pkg::ROOT_STEPS-1:0]   o_root
);
    localparam int SW = ptned_pkg::SUMSQ_BITS;
    localparam int K  = ptned_pkg::ROOT_STEPS;

    logic [SW-1:0] r_n   [K+1];
    logic [SW-1:0] r_res [K+1];

    always_comb begin
        r_n[0]   = i_val;
        r_res[0] = '0;
    end

    for (genvar k = 0; k < K; k++) begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (K - 1 - k));
        logic [SW-1:0] trial;
        always_comb trial = r_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_n[k] >= trial) begin
                r_n[k+1]   <= r_n[k] - trial;
                r_res[k+1] <= (r_res[k] >> 1) + BIT;
            end else begin
                r_n[k+1]   <= r_n[k];
                r_res[k+1] <= r_res[k] >> 1;
            end
        end
    end

    assign o_root = K'(r_res[K]);

endmodule

// File: hw/rtl/point_to_nearest_edge_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_nearest_edge_distance_unit
// Distance from a point to the nearer of the two long edges of a strip.
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  input     i_start / o_busy     i_in  (point, corners a..d)
//  result    o_valid (strobe)     o_out (distance, side, degenerate flag)
//
//  one word is taken every cycle; o_busy stays low
//  each word passes in turn through the lane pipeline (7 plus one stage
//  per fraction bit of the divider), one merge stage, 23 square root stages
//  and the output register
//  reset clears only the valid pipeline; the result strobe lasts one cycle
// ----------------------------------------------------------------------------
module point_to_nearest_edge_distance_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  ptned_pkg::t_in_word  i_in,
    output logic                 o_valid,
    output ptned_pkg::t_out_word o_out
);
    localparam int K     = ptned_pkg::ROOT_STEPS;
    localparam int SW    = ptned_pkg::SUMSQ_BITS;
    localparam int DB    = ptned_pkg::DIST_BITS;
    localparam int TOTAL = FRACTION_BITS + 7 + 1 + K + 1;

    ptned_pkg::t_lane_res right_res;
    ptned_pkg::t_lane_res left_res;

    ptned_lane #(.FRACTION_BITS(FRACTION_BITS)) u_right (
        .i_clk (i_clk),
        .i_px  (i_in.point_x),
        .i_py  (i_in.point_y),
        .i_pz  (i_in.point_z),
        .i_a   (i_in.corner_a),
        .i_b   (i_in.corner_d),
        .o_res (right_res)
    );

    ptned_lane #(.FRACTION_BITS(FRACTION_BITS)) u_left (
        .i_clk (i_clk),
        .i_px  (i_in.point_x),
        .i_py  (i_in.point_y),
        .i_pz  (i_in.point_z),
        .i_a   (i_in.corner_b),
        .i_b   (i_in.corner_c),
        .o_res (left_res)
    );

    // merge: right side wins a tie
    logic [SW-1:0] r_best;
    logic [1:0]    r_tag [K+1];
    always_ff @(posedge i_clk) begin
        if (right_res.sq <= left_res.sq) begin
            r_best <= right_res.sq;
            r_tag[0] <= {1'b0, right_res.dg | left_res.dg};
        end else begin
            r_best <= left_res.sq;
            r_tag[0] <= {1'b1, right_res.dg | left_res.dg};
        end
        for (int k = 0; k < K; k++) begin
            r_tag[k+1] <= r_tag[k];
        end
    end

    logic [K-1:0] root;
    ptned_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_val  (r_best),
        .o_root (root)
    );

    ptned_pkg::t_out_word r_out;
    always_ff @(posedge i_clk) begin
        r_out.edge_distance   <= (root > K'(ptned_pkg::DIST_MAX)) ? ptned_pkg::DIST_MAX
                                                               : DB'(root);
        r_out.nearest_side    <= r_tag[K][1];
        r_out.degenerate_edge <= r_tag[K][0];
    end

    logic [TOTAL-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL-2:0], i_start};
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_vld[TOTAL-1];
    assign o_out   = r_out;

endmodule

// File: verif/tb_point_to_nearest_edge_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_to_nearest_edge_distance_unit
// Drives points and strip corners into the edge distance unit, predicts the
// distance, side and degenerate flag in the testbench and checks every
// result word in order against the prediction.
// ----------------------------------------------------------------------------
module tb_point_to_nearest_edge_distance_unit;

    localparam int CB        = ptned_pkg::COORD_BITS;
    localparam int FRAC      = 16;
    localparam int LATENCY   = FRAC + 32;
    localparam int N_RANDOM  = 880;
    localparam longint LIMIT = 400000;

    typedef longint signed t_vec [3];

    class dist_scoreboard;
        ptned_pkg::t_out_word pending_q[$];
        int                   n_errors;

        function longint signed sext(logic [CB-1:0] v);
            return longint'(signed'(v));
        endfunction

        function longint unsigned sumsq3(t_vec d);
            longint unsigned s;
            longint unsigned m;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? -d[i] : d[i];
                s += m * m;
            end
            return s;
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint unsigned seg_sq(t_vec p, t_vec a, t_vec b, inout bit degen);
            t_vec v, w, d;
            longint signed c1, c2;
            longint unsigned rem, den, t, m, half;
            longint signed r;
            c1 = 0;
            c2 = 0;
            for (int i = 0; i < 3; i++) begin
                v[i] = b[i] - a[i];
                w[i] = p[i] - a[i];
                c1 += w[i] * v[i];
                c2 += v[i] * v[i];
            end
            if (c2 == 0) degen = 1;
            if (c1 <= 0) return sumsq3(w);
            if (c2 <= c1) begin
                for (int i = 0; i < 3; i++) d[i] = p[i] - b[i];
                return sumsq3(d);
            end
            rem  = c1;
            den  = c2;
            t    = 0;
            half = 64'd1 << (FRAC - 1);
            for (int i = 0; i < FRAC; i++) begin
                rem <<= 1;
                t <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    t |= 1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                m = (v[i] < 0 ? -v[i] : v[i]) * t;
                r = longint'((m + half) >> FRAC);
                d[i] = w[i] - (v[i] < 0 ? -r : r);
            end
            return sumsq3(d);
        endfunction

        function void note_word(ptned_pkg::t_in_word x);
            t_vec p, a, b, c, d;
            bit degen;
            longint unsigned right_sq, left_sq, best, root;
            ptned_pkg::t_out_word e;
            p = '{sext(x.point_x), sext(x.point_y), sext(x.point_z)};
            a = '{sext(x.corner_a[59:40]), sext(x.corner_a[39:20]), sext(x.corner_a[19:0])};
            b = '{sext(x.corner_b[59:40]), sext(x.corner_b[39:20]), sext(x.corner_b[19:0])};
            c = '{sext(x.corner_c[59:40]), sext(x.corner_c[39:20]), sext(x.corner_c[19:0])};
            d = '{sext(x.corner_d[59:40]), sext(x.corner_d[39:20]), sext(x.corner_d[19:0])};
            degen    = 0;
            right_sq = seg_sq(p, a, d, degen);
            left_sq  = seg_sq(p, b, c, degen);
            best     = right_sq <= left_sq ? right_sq : left_sq;
            root     = isqrt(best);
            e.edge_distance   = root > ptned_pkg::DIST_MAX ? ptned_pkg::DIST_MAX
                                                           : root[ptned_pkg::DIST_BITS-1:0];
            e.nearest_side    = right_sq > left_sq;
            e.degenerate_edge = degen;
            pending_q.push_back(e);
        endfunction

        function void check_word(ptned_pkg::t_out_word got);
            ptned_pkg::t_out_word e;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.edge_distance !== e.edge_distance) begin
                $error("edge_distance expected %0d got %0d", e.edge_distance, got.edge_distance);
                n_errors++;
            end
            if (got.nearest_side !== e.nearest_side) begin
                $error("nearest_side expected %0d got %0d", e.nearest_side, got.nearest_side);
                n_errors++;
            end
            if (got.degenerate_edge !== e.degenerate_edge) begin
                $error("degenerate_edge expected %0d got %0d", e.degenerate_edge,
                       got.degenerate_edge);
                n_errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_start = 0;
    logic                 o_busy;
    ptned_pkg::t_in_word  i_in = '0;
    logic                 o_valid;
    ptned_pkg::t_out_word o_out;

    dist_scoreboard sb = new();
    longint         cycle_count = 0;

    point_to_nearest_edge_distance_unit #(.FRACTION_BITS(FRAC)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy (o_busy),
        .i_in   (i_in),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) sb.check_word(o_out);
        if (i_rst_n && i_start && !o_busy) sb.note_word(i_in);
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [CB-1:0] rand_coord(int span);
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return CB'($urandom);
        if (k == 1) return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
        return CB'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [ptned_pkg::CORNER_BITS-1:0] pack3(logic [CB-1:0] x,
            logic [CB-1:0] y, logic [CB-1:0] z);
        return {x, y, z};
    endfunction

    // holds start high until the word is taken, then leaves it to the caller
    task automatic send_word(ptned_pkg::t_in_word x);
        i_in    <= x;
        i_start <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = $urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3));
        if (n != 0) begin
            i_start <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    // strip: a and d form the right edge, b and c the left, offset in x
    function automatic ptned_pkg::t_in_word strip_word(int span);
        ptned_pkg::t_in_word w;
        logic [CB-1:0] ax, ay, az, dx, dy, dz, off;
        ax  = rand_coord(span); ay = rand_coord(span); az = rand_coord(span);
        dx  = ax + CB'($urandom_range(0, 2 * span) - span);
        dy  = ay + CB'($urandom_range(0, 2 * span) - span);
        dz  = az;
        off = CB'($urandom_range(0, span));
        w.point_x  = rand_coord(span);
        w.point_y  = rand_coord(span);
        w.point_z  = rand_coord(span);
        w.corner_a = pack3(ax, ay, az);
        w.corner_d = pack3(dx, dy, dz);
        w.corner_b = pack3(ax + off, ay, az);
        w.corner_c = pack3(dx + off, dy, dz);
        if ($urandom_range(0, 19) == 0) w.corner_d = w.corner_a;
        if ($urandom_range(0, 19) == 0) w.corner_c = w.corner_b;
        return w;
    endfunction

    initial begin
        ptned_pkg::t_in_word w;
        logic [319:0]        raw;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: zeros, coordinate extremes, degenerate edges, tie
        w = '0;
        send_word(w);
        w.point_x = 20'h7FFFF; w.point_y = 20'h7FFFF; w.point_z = 20'h7FFFF;
        w.corner_a = {3{20'h80000}}; w.corner_d = {3{20'h80000}};
        w.corner_b = {3{20'h80000}}; w.corner_c = {3{20'h80000}};
        send_word(w);
        w.point_x = 20'h80000; w.point_y = 20'h80000; w.point_z = 20'h80000;
        w.corner_a = {3{20'h7FFFF}}; w.corner_d = {3{20'h80000}};
        w.corner_b = {3{20'h80000}}; w.corner_c = {3{20'h7FFFF}};
        send_word(w);
        // equal distances on both sides
        w = '0;
        w.point_y = 20'd100;
        w.corner_a = pack3(-20'sd50, 20'd0, 20'd0);
        w.corner_d = pack3(-20'sd50, 20'd200, 20'd0);
        w.corner_b = pack3(20'd50, 20'd0, 20'd0);
        w.corner_c = pack3(20'd50, 20'd200, 20'd0);
        send_word(w);
        // left nearer with projections before and past the segment, then right nearer
        w.point_x = 20'd40; w.point_y = -20'sd30;
        send_word(w);
        w.point_y = 20'd900;
        send_word(w);
        w.point_x = -20'sd40; w.point_y = 20'd77;
        send_word(w);
        w = '1;
        send_word(w);
        for (int i = 0; i < 15; i++) begin
            w = strip_word(i < 8 ? 300 : 500000);
            send_word(w);
        end
        // pause until the pipeline has emptied
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) < 8) w = strip_word($urandom_range(0, 1) ? 1000 : 500000);
            else begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom};
                w = raw[$bits(ptned_pkg::t_in_word)-1:0];
            end
            send_word(w);
            if (i == N_RANDOM / 2) drain();
            else sender_gap();
        end
        i_start <= 0;
        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
